FILE: rtl/core/pfs_pkg.sv
package pfs_pkg;

	localparam int SAMPLE_BITS    = 14;
	localparam int INDEX_BITS     = 16;
	localparam int FRAC_BITS      = 4;
	localparam int SCALED_BITS    = SAMPLE_BITS + FRAC_BITS;
	localparam int PED_BITS       = SCALED_BITS;
	localparam int THR_BITS       = 16;
	localparam int LVL_BITS       = PED_BITS + 1;
	localparam int DIFF_BITS      = SCALED_BITS + 1;
	localparam int AREA_BITS      = 35;
	localparam int RUN_BITS       = 16;
	localparam int CFG_DATA_BITS  = PED_BITS;
	localparam int CFG_INDEX_BITS = 3;

	localparam logic [AREA_BITS-1:0] AREA_MAX = {1'b0, {(AREA_BITS-1){1'b1}}};
	localparam logic [AREA_BITS-1:0] AREA_MIN = {1'b1, {(AREA_BITS-1){1'b0}}};
	localparam logic [RUN_BITS-1:0]  RUN_MAX  = {RUN_BITS{1'b1}};

	localparam logic [CFG_INDEX_BITS-1:0] REG_PEDESTAL       = 3'd0;
	localparam logic [CFG_INDEX_BITS-1:0] REG_OPEN_THRESHOLD = 3'd1;
	localparam logic [CFG_INDEX_BITS-1:0] REG_KEEP_THRESHOLD = 3'd2;
	localparam logic [CFG_INDEX_BITS-1:0] REG_MIN_PULSE_W    = 3'd3;
	localparam logic [CFG_INDEX_BITS-1:0] REG_SAT_LEVEL      = 3'd4;
	localparam logic [CFG_INDEX_BITS-1:0] REG_MIN_PLATEAU    = 3'd5;
	localparam logic [CFG_INDEX_BITS-1:0] REG_SAT_CHECK_EN   = 3'd6;

	typedef struct packed {
		logic [PED_BITS-1:0]    pedestal;
		logic [THR_BITS-1:0]    open_threshold;
		logic [THR_BITS-1:0]    keep_threshold;
		logic [INDEX_BITS-1:0]  min_pulse_width;
		logic [SAMPLE_BITS-1:0] saturation_level;
		logic [RUN_BITS-1:0]    min_plateau_length;
		logic                   saturation_check_enable;
	} cfg_t;

	// Everything the back end needs to emit one kept pulse.
	typedef struct packed {
		logic [INDEX_BITS-1:0]       start_idx;
		logic [INDEX_BITS-1:0]       end_idx;
		logic [INDEX_BITS-1:0]       peak_idx;
		logic signed [DIFF_BITS-1:0] peak_val;
		logic signed [AREA_BITS-1:0] area;
		logic                        dropped;
		logic                        bank;
	} desc_t;

	typedef struct packed {
		logic valid;
		logic bank;
	} bank_free_t;

endpackage

FILE: rtl/core/pfs_ram.sv
module pfs_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 32,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             wr_en,
	input  logic [AW-1:0]    wr_addr,
	input  logic [WIDTH-1:0] wr_data,
	input  logic             rd_en,
	input  logic [AW-1:0]    rd_addr,
	output logic [WIDTH-1:0] rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data <= mem_q[rd_addr];
		end
	end

endmodule

FILE: rtl/core/pfs_front.sv
module pfs_front #(
	parameter int MAX_PLATEAUS = 15,
	localparam int CNT_BITS = $clog2(MAX_PLATEAUS + 1),
	localparam int SLOT_BITS = (MAX_PLATEAUS > 1) ? $clog2(MAX_PLATEAUS) : 1
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  pfs_pkg::cfg_t                   cfg,
	input  logic                            in_valid,
	output logic                            in_ready,
	input  logic [pfs_pkg::SAMPLE_BITS-1:0] sample,
	input  logic                            end_of_waveform,
	input  pfs_pkg::bank_free_t             bank_free,
	output logic                            st_we,
	output logic [SLOT_BITS:0]              st_addr,
	output logic [pfs_pkg::RUN_BITS-1:0]    st_data,
	output logic                            desc_push,
	output pfs_pkg::desc_t                  desc,
	output logic [CNT_BITS-1:0]             desc_count
);

	import pfs_pkg::*;

	localparam logic [CNT_BITS-1:0] CNT_LIMIT = CNT_BITS'(MAX_PLATEAUS);

	logic                        in_pulse_q, keep_seen_q, in_plat_q, ovf_q, bank_q;
	logic [INDEX_BITS-1:0]       idx_q, start_q, peak_idx_q;
	logic [SAMPLE_BITS-1:0]      prev_q;
	logic signed [DIFF_BITS-1:0] peak_val_q;
	logic signed [AREA_BITS-1:0] area_q;
	logic [RUN_BITS-1:0]         run_q;
	logic [CNT_BITS-1:0]         cnt_q;
	logic [1:0]                  busy_q;

	logic                        n_in_pulse, n_keep, n_inplat, n_ovf, n_bank;
	logic [INDEX_BITS-1:0]       n_idx, n_start, n_pk_idx;
	logic [SAMPLE_BITS-1:0]      n_prev;
	logic signed [DIFF_BITS-1:0] n_pk_val;
	logic signed [AREA_BITS-1:0] n_area;
	logic [RUN_BITS-1:0]         n_run;
	logic [CNT_BITS-1:0]         n_cnt;

	logic                        fire, ge_open, ge_keep, opening, closing, flat, kept;
	logic [SCALED_BITS-1:0]      scaled;
	logic [LVL_BITS-1:0]         open_lvl, keep_lvl;
	logic signed [DIFF_BITS-1:0] diff;
	logic signed [AREA_BITS:0]   area_sum;
	logic [INDEX_BITS-1:0]       width;
	logic [1:0]                  busy_set, busy_clr;

	assign in_ready = !busy_q[bank_q];
	assign fire     = in_valid && in_ready;
	assign scaled   = {sample, {FRAC_BITS{1'b0}}};
	assign open_lvl = LVL_BITS'(cfg.pedestal) + LVL_BITS'(cfg.open_threshold);
	assign keep_lvl = LVL_BITS'(cfg.pedestal) + LVL_BITS'(cfg.keep_threshold);
	assign ge_open  = LVL_BITS'(scaled) >= open_lvl;
	assign ge_keep  = LVL_BITS'(scaled) >= keep_lvl;
	assign opening  = !in_pulse_q && ge_open;
	assign closing  = in_pulse_q && !ge_open;
	assign diff     = $signed({1'b0, scaled}) - $signed({1'b0, cfg.pedestal});
	assign flat     = (sample <= prev_q) && (sample >= cfg.saturation_level);

	always_comb begin
		n_in_pulse = in_pulse_q;
		n_keep     = keep_seen_q;
		n_inplat   = in_plat_q;
		n_ovf      = ovf_q;
		n_bank     = bank_q;
		n_idx      = idx_q;
		n_start    = start_q;
		n_pk_idx   = peak_idx_q;
		n_prev     = prev_q;
		n_pk_val   = peak_val_q;
		n_area     = area_q;
		n_run      = run_q;
		n_cnt      = cnt_q;
		st_we      = 1'b0;
		st_addr    = {bank_q, cnt_q[SLOT_BITS-1:0]};
		st_data    = run_q;
		desc_push  = 1'b0;
		desc       = '0;
		desc_count = '0;
		width      = '0;
		kept       = 1'b0;
		area_sum   = '0;
		if (fire) begin
			if (opening) begin
				n_in_pulse = 1'b1;
				n_keep     = 1'b0;
				n_start    = idx_q;
				n_pk_idx   = '0;
				n_pk_val   = '0;
				n_area     = '0;
				n_inplat   = 1'b0;
				n_run      = '0;
				n_cnt      = '0;
				n_ovf      = 1'b0;
			end
			if (closing) begin
				// The pulse ended on the previous sample; a pending run counts here.
				desc.end_idx   = idx_q - INDEX_BITS'(1);
				width          = desc.end_idx - start_q;
				kept           = keep_seen_q && (width >= cfg.min_pulse_width);
				desc.start_idx = start_q;
				desc.peak_idx  = peak_idx_q;
				desc.peak_val  = peak_val_q;
				desc.area      = area_q;
				desc.bank      = bank_q;
				if (cfg.saturation_check_enable && (width != '0)) begin
					desc_count   = cnt_q;
					desc.dropped = ovf_q;
					if (in_plat_q && (run_q >= cfg.min_plateau_length)) begin
						if (cnt_q < CNT_LIMIT) begin
							st_we      = 1'b1;
							desc_count = cnt_q + CNT_BITS'(1);
						end else begin
							desc.dropped = 1'b1;
						end
					end
				end
				desc_push = kept;
				n_in_pulse = 1'b0;
				n_keep     = 1'b0;
				n_start    = '0;
				n_pk_idx   = '0;
				n_pk_val   = '0;
				n_area     = '0;
				n_inplat   = 1'b0;
				n_run      = '0;
				n_cnt      = '0;
				n_ovf      = 1'b0;
			end else if (ge_open) begin
				n_keep   = n_keep | ge_keep;
				area_sum = {n_area[AREA_BITS-1], n_area} + (AREA_BITS + 1)'(diff);
				if (area_sum[AREA_BITS] != area_sum[AREA_BITS-1]) begin
					n_area = area_sum[AREA_BITS] ? AREA_MIN : AREA_MAX;
				end else begin
					n_area = area_sum[AREA_BITS-1:0];
				end
				if (diff > n_pk_val) begin
					n_pk_val = diff;
					n_pk_idx = idx_q;
				end
				// The first sample of a window has no predecessor to compare with.
				if (idx_q != '0) begin
					if (flat) begin
						if (!n_inplat) begin
							n_inplat = 1'b1;
							n_run    = RUN_BITS'(1);
						end else if (n_run != RUN_MAX) begin
							n_run = n_run + RUN_BITS'(1);
						end
					end else if (n_inplat) begin
						if (n_run >= cfg.min_plateau_length) begin
							if (n_cnt < CNT_LIMIT) begin
								st_we   = 1'b1;
								st_addr = {bank_q, n_cnt[SLOT_BITS-1:0]};
								st_data = n_run;
								n_cnt   = n_cnt + CNT_BITS'(1);
							end else begin
								n_ovf = 1'b1;
							end
						end
						n_inplat = 1'b0;
						n_run    = '0;
					end
				end
				if (end_of_waveform) begin
					// A pulse cut by the window end reports no plateaus.
					desc.end_idx   = idx_q;
					width          = idx_q - n_start;
					kept           = n_keep && (width >= cfg.min_pulse_width);
					desc.start_idx = n_start;
					desc.peak_idx  = n_pk_idx;
					desc.peak_val  = n_pk_val;
					desc.area      = n_area;
					desc.bank      = bank_q;
					desc_push      = kept;
					n_in_pulse = 1'b0;
					n_keep     = 1'b0;
					n_start    = '0;
					n_pk_idx   = '0;
					n_pk_val   = '0;
					n_area     = '0;
					n_inplat   = 1'b0;
					n_run      = '0;
					n_cnt      = '0;
					n_ovf      = 1'b0;
				end
			end
			n_prev = sample;
			n_idx  = end_of_waveform ? '0 : idx_q + INDEX_BITS'(1);
			if (desc_push) begin
				n_bank = !bank_q;
			end
		end
	end

	always_comb begin
		busy_set = '0;
		busy_clr = '0;
		if (desc_push) begin
			busy_set[bank_q] = 1'b1;
		end
		if (bank_free.valid) begin
			busy_clr[bank_free.bank] = 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_pulse_q  <= 1'b0;
			keep_seen_q <= 1'b0;
			in_plat_q   <= 1'b0;
			ovf_q       <= 1'b0;
			bank_q      <= 1'b0;
			idx_q       <= '0;
			start_q     <= '0;
			peak_idx_q  <= '0;
			prev_q      <= '0;
			peak_val_q  <= '0;
			area_q      <= '0;
			run_q       <= '0;
			cnt_q       <= '0;
			busy_q      <= '0;
		end else begin
			in_pulse_q  <= n_in_pulse;
			keep_seen_q <= n_keep;
			in_plat_q   <= n_inplat;
			ovf_q       <= n_ovf;
			bank_q      <= n_bank;
			idx_q       <= n_idx;
			start_q     <= n_start;
			peak_idx_q  <= n_pk_idx;
			prev_q      <= n_prev;
			peak_val_q  <= n_pk_val;
			area_q      <= n_area;
			run_q       <= n_run;
			cnt_q       <= n_cnt;
			busy_q      <= (busy_q | busy_set) & ~busy_clr;
		end
	end

endmodule

FILE: rtl/core/pfs_queue.sv
module pfs_queue #(
	parameter int WIDTH = 8
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  logic [WIDTH-1:0] push_data,
	input  logic             pop,
	output logic             head_valid,
	output logic [WIDTH-1:0] head_data
);

	// Two entries cover both store banks; the producer never pushes into a full queue.
	logic [WIDTH-1:0] entry_q [2];
	logic             wr_ptr_q, rd_ptr_q;
	logic [1:0]       count_q;

	assign head_valid = count_q != 2'd0;
	assign head_data  = entry_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_ptr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= !wr_ptr_q;
			end
			if (pop) begin
				rd_ptr_q <= !rd_ptr_q;
			end
			count_q <= count_q + {1'b0, push} - {1'b0, pop};
		end
	end

endmodule

FILE: rtl/core/pfs_back.sv
module pfs_back #(
	parameter int MAX_PLATEAUS = 15,
	localparam int CNT_BITS = $clog2(MAX_PLATEAUS + 1),
	localparam int SLOT_BITS = (MAX_PLATEAUS > 1) ? $clog2(MAX_PLATEAUS) : 1
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 q_valid,
	input  pfs_pkg::desc_t                       q_desc,
	input  logic [CNT_BITS-1:0]                  q_count,
	output logic                                 q_pop,
	output logic                                 rd_en,
	output logic [SLOT_BITS:0]                   rd_addr,
	input  logic [pfs_pkg::RUN_BITS-1:0]         rd_data,
	output pfs_pkg::bank_free_t                  bank_free,
	output logic                                 out_valid,
	input  logic                                 out_ready,
	output logic                                 record_kind,
	output logic [pfs_pkg::RUN_BITS-1:0]         plateau_length,
	output logic [pfs_pkg::INDEX_BITS-1:0]       start_time,
	output logic [pfs_pkg::INDEX_BITS-1:0]       end_time,
	output logic [pfs_pkg::INDEX_BITS-1:0]       peak_time,
	output logic signed [pfs_pkg::DIFF_BITS-1:0] peak_height,
	output logic signed [pfs_pkg::AREA_BITS-1:0] pulse_area,
	output logic                                 plateaus_dropped,
	output logic                                 last_of_run
);

	import pfs_pkg::*;

	localparam logic [1:0] ST_IDLE  = 2'd0;
	localparam logic [1:0] ST_NEXT  = 2'd1;
	localparam logic [1:0] ST_WAIT  = 2'd2;
	localparam logic [1:0] ST_PULSE = 2'd3;

	logic [1:0]          state_q;
	desc_t               cur_q;
	logic [CNT_BITS-1:0] cnt_q, k_q;
	logic                out_valid_q;
	logic                out_free, more, load_plat, load_pulse;

	assign out_free   = !out_valid_q || out_ready;
	assign more       = k_q < cnt_q;
	assign load_plat  = (state_q == ST_WAIT) && out_free;
	assign load_pulse = (state_q == ST_PULSE) && out_free;
	assign q_pop      = (state_q == ST_IDLE) && q_valid;
	assign rd_en      = (state_q == ST_NEXT) && more;
	assign rd_addr    = {cur_q.bank, k_q[SLOT_BITS-1:0]};
	assign out_valid  = out_valid_q;

	// The bank is handed back once the pulse record goes out; its plateaus are all read by then.
	assign bank_free.valid = load_pulse;
	assign bank_free.bank  = cur_q.bank;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			k_q         <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (load_plat || load_pulse) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (q_valid) begin
						k_q     <= '0;
						state_q <= ST_NEXT;
					end
				end
				ST_NEXT: begin
					state_q <= more ? ST_WAIT : ST_PULSE;
				end
				ST_WAIT: begin
					if (out_free) begin
						k_q     <= k_q + CNT_BITS'(1);
						state_q <= ST_NEXT;
					end
				end
				ST_PULSE: begin
					if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (q_pop) begin
			cur_q <= q_desc;
			cnt_q <= q_count;
		end
		if (load_plat) begin
			record_kind      <= 1'b0;
			plateau_length   <= rd_data;
			start_time       <= '0;
			end_time         <= '0;
			peak_time        <= '0;
			peak_height      <= '0;
			pulse_area       <= '0;
			plateaus_dropped <= 1'b0;
			last_of_run      <= 1'b0;
		end else if (load_pulse) begin
			record_kind      <= 1'b1;
			plateau_length   <= '0;
			start_time       <= cur_q.start_idx;
			end_time         <= cur_q.end_idx;
			peak_time        <= cur_q.peak_idx;
			peak_height      <= cur_q.peak_val;
			pulse_area       <= cur_q.area;
			plateaus_dropped <= cur_q.dropped;
			last_of_run      <= 1'b1;
		end
	end

endmodule

FILE: rtl/core/pulse_finder_with_saturation_plateaus.sv
// Pulse finder with saturation plateau search.
// Input channel: one raw sample per request with an end-of-window flag, valid/ready.
// Output channel: result records, valid/ready. A kept pulse gives one record per
// stored saturated plateau (record_kind 0) and then its pulse record (record_kind 1,
// last_of_run 1). Configuration goes through a write-only port, one register per write.
// The detector takes one sample per cycle while in_ready is high. A kept pulse is
// handed to the output side through a two-entry descriptor queue; its plateau lengths
// sit in one of two banks of the plateau store. Each plateau record ahead of the pulse
// record goes through the store's registered read and then the output register load.
// in_ready drops only after a kept pulse closes while the other store bank still holds
// a pulse that has not been sent, so it stalls until the older pulse's record is loaded
// into the output register.
// A stalled receiver holds the output register; the detector keeps taking samples
// until both banks are in use.
// Reset clears the detector, the queue and the output side, and loads the register
// reset values; the plateau store needs no clearing.
module pulse_finder_with_saturation_plateaus #(
	parameter int MAX_PLATEAUS = 15
) (
	input  logic                                     clk,
	input  logic                                     arst_n,
	input  logic                                     cfg_write,
	input  logic [pfs_pkg::CFG_INDEX_BITS-1:0]       cfg_index,
	input  logic [pfs_pkg::CFG_DATA_BITS-1:0]        cfg_data,
	input  logic                                     in_valid,
	output logic                                     in_ready,
	input  logic [pfs_pkg::SAMPLE_BITS-1:0]          sample,
	input  logic                                     end_of_waveform,
	output logic                                     out_valid,
	input  logic                                     out_ready,
	output logic                                     record_kind,
	output logic [pfs_pkg::RUN_BITS-1:0]             plateau_length,
	output logic [pfs_pkg::INDEX_BITS-1:0]           start_time,
	output logic [pfs_pkg::INDEX_BITS-1:0]           end_time,
	output logic [pfs_pkg::INDEX_BITS-1:0]           peak_time,
	output logic signed [pfs_pkg::DIFF_BITS-1:0]     peak_height,
	output logic signed [pfs_pkg::AREA_BITS-1:0]     pulse_area,
	output logic                                     plateaus_dropped,
	output logic                                     last_of_run
);

	import pfs_pkg::*;

	localparam int CNT_BITS   = $clog2(MAX_PLATEAUS + 1);
	localparam int SLOT_BITS  = (MAX_PLATEAUS > 1) ? $clog2(MAX_PLATEAUS) : 1;
	localparam int Q_WIDTH    = $bits(desc_t) + CNT_BITS;

	cfg_t                cfg_q;
	bank_free_t          bank_free;
	logic                st_we, desc_push, q_valid, q_pop, rd_en;
	logic [SLOT_BITS:0]  st_addr, rd_addr;
	logic [RUN_BITS-1:0] st_data, rd_data;
	desc_t               desc, q_desc;
	logic [CNT_BITS-1:0] desc_count, q_count;
	logic [Q_WIDTH-1:0]  q_head;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.pedestal                <= '0;
			cfg_q.open_threshold          <= '0;
			cfg_q.keep_threshold          <= '0;
			cfg_q.min_pulse_width         <= '0;
			cfg_q.saturation_level        <= {SAMPLE_BITS{1'b1}};
			cfg_q.min_plateau_length      <= RUN_BITS'(2);
			cfg_q.saturation_check_enable <= 1'b1;
		end else if (cfg_write) begin
			unique case (cfg_index)
				REG_PEDESTAL:       cfg_q.pedestal           <= cfg_data[PED_BITS-1:0];
				REG_OPEN_THRESHOLD: cfg_q.open_threshold     <= cfg_data[THR_BITS-1:0];
				REG_KEEP_THRESHOLD: cfg_q.keep_threshold     <= cfg_data[THR_BITS-1:0];
				REG_MIN_PULSE_W:    cfg_q.min_pulse_width    <= cfg_data[INDEX_BITS-1:0];
				REG_SAT_LEVEL:      cfg_q.saturation_level   <= cfg_data[SAMPLE_BITS-1:0];
				REG_MIN_PLATEAU:    cfg_q.min_plateau_length <= cfg_data[RUN_BITS-1:0];
				REG_SAT_CHECK_EN:   cfg_q.saturation_check_enable <= cfg_data[0];
				default: ;
			endcase
		end
	end

	pfs_front #(
		.MAX_PLATEAUS(MAX_PLATEAUS)
	) u_front (
		.clk             (clk),
		.arst_n          (arst_n),
		.cfg             (cfg_q),
		.in_valid        (in_valid),
		.in_ready        (in_ready),
		.sample          (sample),
		.end_of_waveform (end_of_waveform),
		.bank_free       (bank_free),
		.st_we           (st_we),
		.st_addr         (st_addr),
		.st_data         (st_data),
		.desc_push       (desc_push),
		.desc            (desc),
		.desc_count      (desc_count)
	);

	pfs_ram #(
		.WIDTH(RUN_BITS),
		.DEPTH(2 ** (SLOT_BITS + 1))
	) u_store (
		.clk     (clk),
		.wr_en   (st_we),
		.wr_addr (st_addr),
		.wr_data (st_data),
		.rd_en   (rd_en),
		.rd_addr (rd_addr),
		.rd_data (rd_data)
	);

	pfs_queue #(
		.WIDTH(Q_WIDTH)
	) u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (desc_push),
		.push_data  ({desc_count, desc}),
		.pop        (q_pop),
		.head_valid (q_valid),
		.head_data  (q_head)
	);

	assign q_desc  = q_head[$bits(desc_t)-1:0];
	assign q_count = q_head[Q_WIDTH-1:$bits(desc_t)];

	pfs_back #(
		.MAX_PLATEAUS(MAX_PLATEAUS)
	) u_back (
		.clk              (clk),
		.arst_n           (arst_n),
		.q_valid          (q_valid),
		.q_desc           (q_desc),
		.q_count          (q_count),
		.q_pop            (q_pop),
		.rd_en            (rd_en),
		.rd_addr          (rd_addr),
		.rd_data          (rd_data),
		.bank_free        (bank_free),
		.out_valid        (out_valid),
		.out_ready        (out_ready),
		.record_kind      (record_kind),
		.plateau_length   (plateau_length),
		.start_time       (start_time),
		.end_time         (end_time),
		.peak_time        (peak_time),
		.peak_height      (peak_height),
		.pulse_area       (pulse_area),
		.plateaus_dropped (plateaus_dropped),
		.last_of_run      (last_of_run)
	);

endmodule
